/* hw/rtl/bpfa_pkg.sv */
// bpfa_pkg: shared types and codes of the bitmap page frame allocator
// no dependencies; imported by every module of the block
package bpfa_pkg;

    // bitmap geometry
    localparam int FRAMES_PER_WORD = 64;
    localparam int WORD_SHIFT      = 6;
    localparam int BIT_W           = 6;

    // field widths
    localparam int OP_W       = 2;
    localparam int PAGE_W     = 16;
    localparam int PCOUNT_W   = 17;
    localparam int STATUS_W   = 2;
    localparam int FRAME_W    = 16;
    localparam int START_W    = 10;
    localparam int WCOUNT_W   = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    // reset values of the configuration registers
    localparam logic [START_W-1:0]  START_WORD_RST = 10'd0;
    localparam logic [WCOUNT_W-1:0] WORD_COUNT_RST = 11'd1024;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE      = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd2;
    localparam logic [OP_W-1:0] OP_MARK_USED = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOM   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_WORD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT = 1'b1;

    // word unit modes
    localparam logic [1:0] WU_TAKE  = 2'd0;
    localparam logic [1:0] WU_SET   = 2'd1;
    localparam logic [1:0] WU_CLEAR = 2'd2;

    typedef logic [FRAMES_PER_WORD-1:0] word_t;

    // command to the shared word unit: bits lo..hi-1 form the span
    typedef struct packed {
        logic [1:0]       mode;
        logic [BIT_W-1:0] lo;
        logic [BIT_W:0]   hi;
    } word_cmd_t;

endpackage

/* hw/rtl/bpfa_ram.sv */
// bpfa_ram: bitmap store, one write port and one read port with registered data
// depends on bpfa_pkg for the word type
module bpfa_ram
    import bpfa_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  word_t         wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output word_t         rdata
);

    word_t mem [DEPTH];
    word_t rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bpfa_word_unit.sv */
// bpfa_word_unit: shared word operation, lowest-free take or span set/clear
// depends on bpfa_pkg for word_t and word_cmd_t
module bpfa_word_unit
    import bpfa_pkg::*;
(
    input  word_t            word_in,
    input  word_cmd_t        cmd,
    output word_t            word_out,
    output logic             nonzero,
    output logic [BIT_W-1:0] bit_index
);

    localparam word_t ALL_ONES = '1;

    word_t lowest;
    word_t upper;
    word_t mask;

    // isolate the lowest set bit and encode its position
    always_comb
    begin
        lowest    = word_in & (~word_in + word_t'(1));
        bit_index = '0;
        for (int j = 0; j < FRAMES_PER_WORD; j++)
        begin
            if (lowest[j])
            begin
                bit_index = bit_index | BIT_W'(j);
            end
        end
    end

    assign nonzero = |word_in;

    // span mask for bits lo..hi-1
    always_comb
    begin
        upper = cmd.hi[BIT_W] ? ALL_ONES : ~(ALL_ONES << cmd.hi[BIT_W-1:0]);
        mask  = (ALL_ONES << cmd.lo) & upper;
    end

    // result word
    always_comb
    begin
        case (cmd.mode)
            WU_TAKE:  word_out = word_in & (word_in - word_t'(1));
            WU_SET:   word_out = word_in | mask;
            WU_CLEAR: word_out = word_in & ~mask;
            default:  word_out = word_in;
        endcase
    end

endmodule

/* hw/rtl/bpfa_seq.sv */
// bpfa_seq: sequencer that clears the store, scans words and updates them
// depends on bpfa_pkg, bpfa_ram and bpfa_word_unit
module bpfa_seq
    import bpfa_pkg::*;
#(
    parameter int BITMAP_WORDS = 1024,
    parameter int LW           = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [OP_W-1:0]     op,
    input  logic [PAGE_W-1:0]   page_number,
    input  logic [PCOUNT_W-1:0] page_count,
    input  logic [START_W-1:0]  start_word,
    input  logic [LW-1:0]       word_limit,
    output logic                busy,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [FRAME_W-1:0]  frame
);

    localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_RANGE = 3'd3;
    localparam logic [2:0] S_ISSUE = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [LW-1:0]       scan_reg, scan_next;
    logic                done_reg, done_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [PCOUNT_W-1:0] count_reg, count_next;
    logic [PCOUNT_W-1:0] end_reg, end_next;
    logic                empty_reg, empty_next;
    logic [LW-1:0]       chk_reg, chk_next;
    logic [LW-1:0]       bound_reg, bound_next;
    logic [LW-1:0]       first_wd_reg, first_wd_next;
    logic [LW-1:0]       last_wd_reg, last_wd_next;
    logic [BIT_W-1:0]    first_lo_reg, first_lo_next;
    logic [BIT_W:0]      last_hi_reg, last_hi_next;
    logic [STATUS_W-1:0] mstatus_reg, mstatus_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    word_t               ram_wdata;
    logic                ram_re;
    word_t               ram_rdata;

    word_cmd_t           cmd;
    word_t               word_new;
    logic                word_nonzero;
    logic [BIT_W-1:0]    word_bit;

    logic [PCOUNT_W-1:0] cnt;
    logic [LW+5:0]       limit_frames;
    logic [PCOUNT_W-1:0] stop;
    logic [PCOUNT_W-1:0] last_frame;
    logic [STATUS_W-1:0] range_status;

    bpfa_ram #(
        .DEPTH (BITMAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    bpfa_word_unit u_word (
        .word_in   (ram_rdata),
        .cmd       (cmd),
        .word_out  (word_new),
        .nonzero   (word_nonzero),
        .bit_index (word_bit)
    );

    // word unit command for the word under check
    always_comb
    begin
        if (op_reg == OP_ALLOC)
        begin
            cmd.mode = WU_TAKE;
        end
        else if (op_reg == OP_MARK_USED)
        begin
            cmd.mode = WU_CLEAR;
        end
        else
        begin
            cmd.mode = WU_SET;
        end
        cmd.lo = (chk_reg == first_wd_reg) ? first_lo_reg : '0;
        cmd.hi = (chk_reg == last_wd_reg) ? last_hi_reg : (BIT_W+1)'(FRAMES_PER_WORD);
    end

    // range bounds, taken in the setup and range states
    always_comb
    begin
        cnt          = (op_reg == OP_FREE) ? PCOUNT_W'(1) : count_reg;
        limit_frames = {word_limit, 6'b0};
        if (32'(end_reg) < 32'(limit_frames))
        begin
            stop = end_reg;
        end
        else
        begin
            stop = PCOUNT_W'(limit_frames);
        end
        last_frame   = stop - PCOUNT_W'(1);
        range_status = ((32'(end_reg) > 32'(limit_frames)) && !empty_reg)
                       ? STATUS_RANGE : STATUS_OK;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        done_next     = 1'b0;
        op_next       = op_reg;
        page_next     = page_reg;
        count_next    = count_reg;
        end_next      = end_reg;
        empty_next    = empty_reg;
        chk_next      = chk_reg;
        bound_next    = bound_reg;
        first_wd_next = first_wd_reg;
        last_wd_next  = last_wd_reg;
        first_lo_next = first_lo_reg;
        last_hi_next  = last_hi_reg;
        mstatus_next  = mstatus_reg;
        status_next   = status_reg;
        frame_next    = frame_reg;
        ram_we        = 1'b0;
        ram_waddr     = chk_reg[AW-1:0];
        ram_wdata     = word_new;
        ram_re        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg[AW-1:0];
                ram_wdata = '0;
                if (scan_reg == LW'(BITMAP_WORDS - 1))
                begin
                    scan_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + LW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    page_next  = page_number;
                    count_next = page_count;
                    state_next = S_SETUP;
                end
            end

            S_SETUP:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (32'(start_word) >= 32'(word_limit))
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_OOM;
                        frame_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        scan_next  = LW'(start_word);
                        bound_next = word_limit;
                        state_next = S_ISSUE;
                    end
                end
                else
                begin
                    end_next   = PCOUNT_W'(page_reg) + cnt;
                    empty_next = (cnt == '0);
                    state_next = S_RANGE;
                end
            end

            S_RANGE:
            begin
                if (PCOUNT_W'(page_reg) >= stop)
                begin
                    done_next   = 1'b1;
                    status_next = range_status;
                    frame_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    scan_next     = LW'(page_reg >> WORD_SHIFT);
                    first_wd_next = LW'(page_reg >> WORD_SHIFT);
                    first_lo_next = page_reg[BIT_W-1:0];
                    last_wd_next  = LW'(last_frame >> WORD_SHIFT);
                    last_hi_next  = {1'b0, last_frame[BIT_W-1:0]} + (BIT_W+1)'(1);
                    bound_next    = LW'(last_frame >> WORD_SHIFT) + LW'(1);
                    mstatus_next  = range_status;
                    state_next    = S_ISSUE;
                end
            end

            S_ISSUE:
            begin
                ram_re     = 1'b1;
                chk_next   = scan_reg;
                scan_next  = scan_reg + LW'(1);
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (op_reg == OP_ALLOC && word_nonzero)
                begin
                    // first free frame found: take it
                    ram_we      = 1'b1;
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    frame_next  = FRAME_W'((32'(chk_reg) << WORD_SHIFT) | 32'(word_bit));
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_we = (op_reg != OP_ALLOC);
                    if (scan_reg < bound_reg)
                    begin
                        // overlap the next read with this word's write (no write when allocating)
                        ram_re    = 1'b1;
                        chk_next  = scan_reg;
                        scan_next = scan_reg + LW'(1);
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = (op_reg == OP_ALLOC) ? STATUS_OOM : mstatus_reg;
                        frame_next  = '0;
                        state_next  = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            scan_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            done_reg  <= done_next;
        end
    end

    // transaction payload and scan bounds
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        page_reg     <= page_next;
        count_reg    <= count_next;
        end_reg      <= end_next;
        empty_reg    <= empty_next;
        chk_reg      <= chk_next;
        bound_reg    <= bound_next;
        first_wd_reg <= first_wd_next;
        last_wd_reg  <= last_wd_next;
        first_lo_reg <= first_lo_next;
        last_hi_reg  <= last_hi_next;
        mstatus_reg  <= mstatus_next;
        status_reg   <= status_next;
        frame_reg    <= frame_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign frame  = frame_reg;

endmodule

/* hw/rtl/bitmap_page_frame_allocator_top.sv */
// bitmap page frame allocator, top level: config registers and sequencer
// allocate runs setup, issue, a check per word; free and mark add range; each ends early
//   if nothing is scanned; one word per cycle, next read overlapping any write
// throughput: a new transaction is taken in the cycle its predecessor's done strobes
// reset: rst_n async; a clearing pass over all BITMAP_WORDS words zeroes the bitmap, busy high
// results are strobed for one cycle on done; the receiver cannot stall
module bitmap_page_frame_allocator_top
    import bpfa_pkg::*;
#(
    parameter int BITMAP_WORDS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       op,
    input  logic [PAGE_W-1:0]     page_number,
    input  logic [PCOUNT_W-1:0]   page_count,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [FRAME_W-1:0]    frame,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = $clog2(BITMAP_WORDS + 1);

    logic [START_W-1:0]  start_word_reg, start_word_next;
    logic [WCOUNT_W-1:0] word_count_reg, word_count_next;
    logic [LW-1:0]       word_limit;

    // configuration writes
    always_comb
    begin
        start_word_next = start_word_reg;
        word_count_next = word_count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_WORD: start_word_next = cfg_data[START_W-1:0];
                CFG_WORD_COUNT: word_count_next = cfg_data[WCOUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= START_WORD_RST;
            word_count_reg <= WORD_COUNT_RST;
        end
        else
        begin
            start_word_reg <= start_word_next;
            word_count_reg <= word_count_next;
        end
    end

    // words in use
    assign word_limit = (32'(word_count_reg) < BITMAP_WORDS) ? LW'(word_count_reg)
                                                              : LW'(BITMAP_WORDS);

    bpfa_seq #(
        .BITMAP_WORDS (BITMAP_WORDS),
        .LW           (LW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .page_number (page_number),
        .page_count  (page_count),
        .start_word  (start_word_reg),
        .word_limit  (word_limit),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .frame       (frame)
    );

endmodule

/* hw/rtl/bpfa_checker.sv */
// bpfa_checker: port-level checks of the allocator, bound to the top level
// depends on bpfa_pkg for status codes
module bpfa_checker
    import bpfa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic [FRAME_W-1:0]  frame
);

    // an accepted transaction keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accepted transaction");

    // a result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // one strobe per transaction
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    // failed results carry frame zero
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (frame == '0))
        else $error("nonzero frame on failed transaction");

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker u_bpfa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .frame  (frame)
);
